### sv/sflm_pkg.sv
// Package for the sorted frequency-list merge core.
// Holds list depth, field widths and input kind and merge mode codes.
// No dependencies.
package sflm_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int KEY_BITS   = 31;
   localparam int FREQ_BITS  = 16;
   localparam int SUM_BITS   = FREQ_BITS + 1;
   localparam int PTR_BITS   = $clog2(LIST_DEPTH + 1);
   localparam int IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   typedef logic [1:0]          kind_type;
   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [FREQ_BITS-1:0] freq_type;
   typedef logic [SUM_BITS-1:0] sum_type;
   typedef logic [PTR_BITS-1:0] ptr_type;

   localparam kind_type KIND_LOAD_A = 2'd0;
   localparam kind_type KIND_LOAD_B = 2'd1;
   localparam kind_type KIND_RUN    = 2'd2;

   localparam logic MODE_UNION = 1'b0;
   localparam logic MODE_ISECT = 1'b1;

endpackage

### sv/sorted_freq_list_merge_core.sv
// Top level of the sorted frequency-list merge core: list memories, merge sequencer.
// Uses sflm_pkg for widths and codes.
//
// channel   | ports                                          | handshake
// request   | req_kind, req_entry_key, req_entry_freq        | start & !busy
// response  | rsp_out_key, rsp_out_freq, rsp_is_last/empty   | rsp_strobe, one cycle
// csr       | csr_merge_mode                                 | csr_valid & csr_ready
//
// A load writes its entry while idle; busy stays low.
// A run walks both lists with one compare/add unit, each step passing a memory read state
// and a compare and advance state, then a finish state: busy stays high for the run, steps <= lenA+lenB.
// Synchronous reset empties both lists and sets union mode.
// Results leave on rsp_strobe for one cycle each; the receiver cannot stall.
module sorted_freq_list_merge_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sflm_pkg::kind_type     req_kind,
   input  sflm_pkg::key_type      req_entry_key,
   input  sflm_pkg::freq_type     req_entry_freq,
   output logic                   rsp_strobe,
   output sflm_pkg::key_type      rsp_out_key,
   output sflm_pkg::sum_type      rsp_out_freq,
   output logic                   rsp_is_last,
   output logic                   rsp_is_empty,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_merge_mode
);
   import sflm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_CMP    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   key_type  a_key_mem  [LIST_DEPTH];
   freq_type a_freq_mem [LIST_DEPTH];
   key_type  b_key_mem  [LIST_DEPTH];
   freq_type b_freq_mem [LIST_DEPTH];

   logic [1:0] state_ff, state_in;
   ptr_type    len_a_ff, len_a_in, len_b_ff, len_b_in;
   ptr_type    ia_ff, ia_in, ib_ff, ib_in;
   logic       mode_ff, mode_in;
   logic       pend_valid_ff, pend_valid_in;
   key_type    pend_key_ff, pend_key_in;
   sum_type    pend_freq_ff, pend_freq_in;
   logic       strobe_ff, strobe_in;
   key_type    out_key_ff, out_key_in;
   sum_type    out_freq_ff, out_freq_in;
   logic       last_ff, last_in, empty_ff, empty_in;

   key_type  rd_a_key_ff, rd_b_key_ff;
   freq_type rd_a_freq_ff, rd_b_freq_ff;

   logic accept, wr_a, wr_b;
   logic a_has, b_has, key_eq, key_gt, take_a, take_b, emit;
   key_type sel_key;
   sum_type sel_freq;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;
   assign accept    = start & ~busy;
   assign wr_a      = accept && (req_kind == KIND_LOAD_A) && (len_a_ff < PTR_BITS'(LIST_DEPTH));
   assign wr_b      = accept && (req_kind == KIND_LOAD_B) && (len_b_ff < PTR_BITS'(LIST_DEPTH));

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_key  = out_key_ff;
   assign rsp_out_freq = out_freq_ff;
   assign rsp_is_last  = last_ff;
   assign rsp_is_empty = empty_ff;

   // shared compare and add unit
   assign a_has  = ia_ff < len_a_ff;
   assign b_has  = ib_ff < len_b_ff;
   assign key_eq = rd_a_key_ff == rd_b_key_ff;
   assign key_gt = rd_a_key_ff > rd_b_key_ff;

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (!a_has) begin
         take_b = 1'b1;
      end else if (!b_has) begin
         take_a = 1'b1;
      end else if (key_eq) begin
         take_a = 1'b1;
         take_b = 1'b1;
      end else if (key_gt) begin
         take_b = 1'b1;
      end else begin
         take_a = 1'b1;
      end
   end

   assign sel_key  = take_a ? rd_a_key_ff : rd_b_key_ff;
   assign sel_freq = (take_a ? {1'b0, rd_a_freq_ff} : '0) + (take_b ? {1'b0, rd_b_freq_ff} : '0);
   assign emit     = (take_a & take_b) | (mode_ff == MODE_UNION);

   always_comb begin
      state_in      = state_ff;
      len_a_in      = len_a_ff;
      len_b_in      = len_b_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      mode_in       = mode_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_freq_in  = pend_freq_ff;
      strobe_in     = 1'b0;
      out_key_in    = out_key_ff;
      out_freq_in   = out_freq_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_merge_mode;
      end
      case (state_ff)
         ST_IDLE: begin
            if (wr_a) begin
               len_a_in = len_a_ff + PTR_BITS'(1);
            end
            if (wr_b) begin
               len_b_in = len_b_ff + PTR_BITS'(1);
            end
            if (accept && req_kind == KIND_RUN) begin
               ia_in         = '0;
               ib_in         = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            if (a_has || b_has) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CMP: begin
            if (take_a) begin
               ia_in = ia_ff + PTR_BITS'(1);
            end
            if (take_b) begin
               ib_in = ib_ff + PTR_BITS'(1);
            end
            if (emit) begin
               if (pend_valid_ff) begin
                  strobe_in   = 1'b1;
                  out_key_in  = pend_key_ff;
                  out_freq_in = pend_freq_ff;
                  last_in     = 1'b0;
                  empty_in    = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_key_in   = sel_key;
               pend_freq_in  = sel_freq;
            end
            state_in = ST_READ;
         end
         ST_FINISH: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            if (pend_valid_ff) begin
               out_key_in  = pend_key_ff;
               out_freq_in = pend_freq_ff;
               empty_in    = 1'b0;
            end else begin
               out_key_in  = '0;
               out_freq_in = '0;
               empty_in    = 1'b1;
            end
            pend_valid_in = 1'b0;
            len_a_in      = '0;
            len_b_in      = '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_a_ff      <= '0;
         len_b_ff      <= '0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         mode_ff       <= MODE_UNION;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_a_ff      <= len_a_in;
         len_b_ff      <= len_b_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_key_ff  <= pend_key_in;
      pend_freq_ff <= pend_freq_in;
      out_key_ff   <= out_key_in;
      out_freq_ff  <= out_freq_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_key_mem[len_a_ff[IDX_BITS-1:0]]  <= req_entry_key;
         a_freq_mem[len_a_ff[IDX_BITS-1:0]] <= req_entry_freq;
      end
      if (wr_b) begin
         b_key_mem[len_b_ff[IDX_BITS-1:0]]  <= req_entry_key;
         b_freq_mem[len_b_ff[IDX_BITS-1:0]] <= req_entry_freq;
      end
      rd_a_key_ff  <= a_key_mem[ia_ff[IDX_BITS-1:0]];
      rd_a_freq_ff <= a_freq_mem[ia_ff[IDX_BITS-1:0]];
      rd_b_key_ff  <= b_key_mem[ib_ff[IDX_BITS-1:0]];
      rd_b_freq_ff <= b_freq_mem[ib_ff[IDX_BITS-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> ((ia_ff <= len_a_ff) && (ib_ff <= len_b_ff)))
      else $error("merge pointer past list length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_a_ff <= PTR_BITS'(LIST_DEPTH)) && (len_b_ff <= PTR_BITS'(LIST_DEPTH)))
      else $error("list length past depth");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && empty_ff) |-> last_ff)
      else $error("empty result not marked last");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (strobe_ff && last_ff && len_a_ff == '0 && len_b_ff == '0))
      else $error("run end did not clear lists or send last result");
`endif

endmodule

### test/sorted_freq_list_merge_core_tb.sv
// Self-checking testbench for sorted_freq_list_merge_core: directed and random load/merge
// sequences in union and intersection mode, checked against an in-bench list merge predictor.
// Depends on sflm_pkg and the sorted_freq_list_merge_core RTL.
module sorted_freq_list_merge_core_tb;
   import sflm_pkg::*;

   localparam kind_type KIND_UNUSED  = 2'd3;
   localparam key_type  KEY_MAX      = '1;
   localparam int       RANDOM_ITEMS = 100;
   localparam int       REPORT_LIMIT = 10;
   localparam int       CYCLE_LIMIT  = 400000;
   localparam int       SETTLE       = 8;

   typedef struct packed {
      key_type key;
      sum_type freq;
      logic    last;
      logic    empty;
   } merged_entry_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     start;
   logic     busy;
   kind_type req_kind;
   key_type  req_entry_key;
   freq_type req_entry_freq;
   logic     rsp_strobe;
   key_type  rsp_out_key;
   sum_type  rsp_out_freq;
   logic     rsp_is_last;
   logic     rsp_is_empty;
   logic     csr_valid;
   logic     csr_ready;
   logic     csr_merge_mode;

   // predictor state
   key_type  list_a_key [LIST_DEPTH];
   freq_type list_a_freq[LIST_DEPTH];
   key_type  list_b_key [LIST_DEPTH];
   freq_type list_b_freq[LIST_DEPTH];
   int       len_a;
   int       len_b;
   logic     cur_mode;

   merged_entry_type merged_q[$];

   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  loads_taken     = 0;
   int  loads_dropped   = 0;
   int  merges_run      = 0;
   int  isect_merges    = 0;
   int  empty_answers   = 0;
   int  cycle_count     = 0;
   bit  no_idle         = 1'b0;

   sorted_freq_list_merge_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_entry_key  (req_entry_key),
      .req_entry_freq (req_entry_freq),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_freq   (rsp_out_freq),
      .rsp_is_last    (rsp_is_last),
      .rsp_is_empty   (rsp_is_empty),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_merge_mode (csr_merge_mode)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  merged_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic freq_type rand_freq();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return freq_type'($urandom);
   endfunction

   // two-pointer merge of the held lists; queue the results and clear both lists
   function automatic void predict_merge();
      int               ia;
      int               ib;
      logic             emit;
      logic             have_pending;
      merged_entry_type pending;
      merged_entry_type cur;
      ia = 0;
      ib = 0;
      have_pending = 1'b0;
      pending = '0;
      merges_run++;
      if (cur_mode == MODE_ISECT) isect_merges++;
      while (ia < len_a || ib < len_b) begin
         cur = '0;
         emit = (cur_mode == MODE_UNION);
         if (ia >= len_a) begin
            cur.key  = list_b_key[ib];
            cur.freq = sum_type'(list_b_freq[ib]);
            ib++;
         end else if (ib >= len_b || list_a_key[ia] < list_b_key[ib]) begin
            cur.key  = list_a_key[ia];
            cur.freq = sum_type'(list_a_freq[ia]);
            ia++;
         end else if (list_a_key[ia] == list_b_key[ib]) begin
            cur.key  = list_a_key[ia];
            cur.freq = sum_type'(list_a_freq[ia]) + sum_type'(list_b_freq[ib]);
            emit = 1'b1;
            ia++;
            ib++;
         end else begin
            cur.key  = list_b_key[ib];
            cur.freq = sum_type'(list_b_freq[ib]);
            ib++;
         end
         if (emit) begin
            if (have_pending) merged_q.push_back(pending);
            pending = cur;
            have_pending = 1'b1;
         end
      end
      if (have_pending) begin
         pending.last = 1'b1;
         merged_q.push_back(pending);
      end else begin
         cur = '0;
         cur.last  = 1'b1;
         cur.empty = 1'b1;
         merged_q.push_back(cur);
         empty_answers++;
      end
      len_a = 0;
      len_b = 0;
   endfunction

   function automatic void apply_item(kind_type kind, key_type key, freq_type freq);
      case (kind)
         KIND_LOAD_A: begin
            if (len_a < LIST_DEPTH) begin
               list_a_key[len_a]  = key;
               list_a_freq[len_a] = freq;
               len_a++;
               loads_taken++;
            end else begin
               loads_dropped++;
            end
         end
         KIND_LOAD_B: begin
            if (len_b < LIST_DEPTH) begin
               list_b_key[len_b]  = key;
               list_b_freq[len_b] = freq;
               len_b++;
               loads_taken++;
            end else begin
               loads_dropped++;
            end
         end
         KIND_RUN: predict_merge();
         default: ;
      endcase
   endfunction

   // drive one item, hold until transfer, then idle a random gap, which may be zero
   task automatic send_item(input kind_type kind, input key_type key, input freq_type freq);
      int gap;
      req_kind       = kind;
      req_entry_key  = key;
      req_entry_freq = freq;
      start          = 1'b1;
      do @(posedge clock); while (busy);
      apply_item(kind, key, freq);
      @(negedge clock);
      gap = rand_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle(input int settle);
      start = 1'b0;
      do @(posedge clock); while (merged_q.size() != 0 || busy);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_idle(SETTLE);
      csr_merge_mode = mode;
      csr_valid      = 1'b1;
      do @(posedge clock); while (!csr_ready);
      cur_mode = mode;
      @(negedge clock);
      csr_valid = 1'b0;
      repeat (rand_gap()) @(negedge clock);
   endtask

   task automatic flag_mismatch(input string field, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s of result %0d: expected %0h, got %0h", field,
                  results_checked, want, got);
   endtask

   always @(posedge clock) begin
      merged_entry_type want;
      if (!reset && rsp_strobe) begin
         if (merged_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result with nothing pending: key %0h freq %0h last %b empty %b",
                        rsp_out_key, rsp_out_freq, rsp_is_last, rsp_is_empty);
         end else begin
            want = merged_q.pop_front();
            if (rsp_out_key !== want.key) flag_mismatch("key", want.key, rsp_out_key);
            if (rsp_out_freq !== want.freq) flag_mismatch("freq", want.freq, rsp_out_freq);
            if (rsp_is_last !== want.last) flag_mismatch("last", want.last, rsp_is_last);
            if (rsp_is_empty !== want.empty) flag_mismatch("empty", want.empty, rsp_is_empty);
            results_checked++;
         end
      end
   end

   task automatic test_empty_run();
      send_item(KIND_RUN, '0, '0);
   endtask

   task automatic test_key_extremes();
      send_item(KIND_LOAD_A, '0, '1);
      send_item(KIND_LOAD_A, KEY_MAX, '0);
      send_item(KIND_LOAD_B, '0, '1);
      send_item(KIND_LOAD_B, key_type'(5), freq_type'(1));
      send_item(KIND_LOAD_B, KEY_MAX, '1);
      send_item(KIND_RUN, KEY_MAX, '1);
   endtask

   task automatic test_one_sided_union();
      send_item(KIND_LOAD_A, key_type'(4), freq_type'(4));
      send_item(KIND_RUN, '0, '0);
      send_item(KIND_LOAD_B, key_type'(9), freq_type'(9));
      send_item(KIND_RUN, '0, '0);
   endtask

   task automatic test_unused_kind();
      write_mode(MODE_ISECT);
      send_item(KIND_LOAD_A, key_type'(7), freq_type'(3));
      send_item(KIND_UNUSED, key_type'(7), freq_type'(9));
      send_item(KIND_LOAD_B, key_type'(7), freq_type'(4));
      send_item(KIND_RUN, '0, '0);
   endtask

   task automatic test_disjoint_isect();
      send_item(KIND_LOAD_A, key_type'(1), freq_type'(1));
      send_item(KIND_LOAD_B, key_type'(2), freq_type'(2));
      send_item(KIND_RUN, '0, '0);
   endtask

   task automatic test_unsorted_walk();
      write_mode(MODE_UNION);
      send_item(KIND_LOAD_A, key_type'(10), freq_type'(1));
      send_item(KIND_LOAD_A, key_type'(3), freq_type'(2));
      send_item(KIND_LOAD_B, key_type'(5), freq_type'(5));
      send_item(KIND_RUN, '0, '0);
   endtask

   task automatic test_random_merges();
      int              n_items;
      int              set_len;
      int              dest;
      int              r;
      int              i;
      bit              wide;
      bit              unsorted_set;
      longint unsigned acc;
      key_type         key;
      n_items = 0;
      while (n_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) write_mode(logic'($urandom_range(0, 1)));
         no_idle = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 75) set_len = $urandom_range(0, 8);
         else if (r < 93) set_len = $urandom_range(9, 16);
         else set_len = $urandom_range(17, 24);
         wide = ($urandom_range(0, 2) == 0);
         unsorted_set = ($urandom_range(0, 7) == 0);
         acc = wide ? longint'($urandom_range(0, KEY_MAX)) : longint'($urandom_range(0, 20));
         for (i = 0; i < set_len && acc <= KEY_MAX; i++) begin
            key = key_type'(acc);
            if (unsorted_set && $urandom_range(0, 2) == 0)
               key = wide ? key_type'($urandom) : key_type'($urandom_range(0, 63));
            dest = $urandom_range(0, 2);
            if (dest != 1) begin
               send_item(KIND_LOAD_A, key, rand_freq());
               n_items++;
            end
            if (dest != 0) begin
               send_item(KIND_LOAD_B, key, rand_freq());
               n_items++;
            end
            if ($urandom_range(0, 19) == 0)
               send_item(KIND_UNUSED, key_type'($urandom), rand_freq());
            acc += wide ? $urandom_range(1, 1 << 24) : $urandom_range(0, 3);
         end
         send_item(KIND_RUN, key_type'($urandom), freq_type'($urandom));
         n_items++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_LOAD_A;
      req_entry_key  = '0;
      req_entry_freq = '0;
      csr_valid      = 1'b0;
      csr_merge_mode = MODE_UNION;
      len_a          = 0;
      len_b          = 0;
      cur_mode       = MODE_UNION;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_run();
      test_key_extremes();
      test_one_sided_union();
      test_unused_kind();
      test_disjoint_isect();
      test_unsorted_walk();
      test_random_merges();

      wait_idle(4 * LIST_DEPTH + 4);
      $display("ran %0d merges (%0d intersection, %0d empty), %0d results checked",
               merges_run, isect_merges, empty_answers, results_checked);
      $display("loaded %0d entries, %0d dropped past list depth, %0d mismatches",
               loads_taken, loads_dropped, mismatch_count);
      if (mismatch_count == 0 && merged_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
sv/sflm_pkg.sv
sv/sorted_freq_list_merge_core.sv
test/sorted_freq_list_merge_core_tb.sv
